// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// prop must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
// cond must never be true out of reset
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_AT(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ----- hdl/ihs_pkg.sv -----
// ----------------------------------------------------------------------------
// ihs_pkg
// Types and constants of the implicit heat step tridiagonal unit.
// ----------------------------------------------------------------------------
package ihs_pkg;

    // wide intermediate width (den, rhs, num, shifted products)
    localparam int MQ_W   = 50;
    localparam int OPND_W = 33;
    localparam int PROD_W = 2 * OPND_W;
    localparam int FRAC_W = 16;
    localparam int Q_ONE  = 65536;

    // register indexes on the config port
    localparam logic REG_GAMMA = 1'b0;
    localparam logic REG_TSTEP = 1'b1;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FORCE = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FW_RD,
        ST_FW_M1,
        ST_FW_M2,
        ST_FW_M3,
        ST_FW_M4,
        ST_DIV_A,
        ST_DIV_B,
        ST_BS_OUT,
        ST_BS_RD,
        ST_BS_MUL,
        ST_BS_ADD
    } t_state;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_CHECK,
        DV_ITER,
        DV_DONE
    } t_div_state;

endpackage

// ----- hdl/implicit_heat_step_tridiagonal_unit.sv -----
// ----------------------------------------------------------------------------
// implicit_heat_step_tridiagonal_unit
// One implicit 1-D heat step by Thomas algorithm, signed Q16.16.
// ----------------------------------------------------------------------------
// A load transaction (op 0) writes the next grid point.
// A forcing transaction (op 1) runs one forward-sweep point: three products on
// a shared 33x33 multiplier and two quotients on the serial divider, each of
// them a check step, 33 quotient steps and a done step. The forcing sample for
// point N-1 then walks the grid back from N to 0 and emits N+1 points, with a
// RAM read, a multiply and an add for each interior point. The block is not
// ready for input while a forcing transaction or the walk is in progress.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module implicit_heat_step_tridiagonal_unit #(
    parameter int GRID_INTERVALS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_op,
    input  logic signed [31:0] i_sample_value,
    input  logic signed [31:0] i_left_edge,
    input  logic signed [31:0] i_right_edge,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [5:0]         o_point_index,
    output logic signed [31:0] o_point_value,
    output logic               o_last_point,
    // config port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import ihs_pkg::*;

    localparam int NPTS  = GRID_INTERVALS + 1;
    localparam int IDX_W = $clog2(NPTS);
    localparam logic [IDX_W-1:0] N_IDX   = IDX_W'(GRID_INTERVALS);
    localparam logic [IDX_W-1:0] IDX_ONE = IDX_W'(1);

    function automatic logic signed [MQ_W-1:0] mq(input logic signed [PROD_W-1:0] p);
        return p[PROD_W-1:FRAC_W];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [MQ_W:0] x);
        if (x > (MQ_W+1)'(64'sh7fff_ffff)) return 32'sh7fff_ffff;
        if (x < -(MQ_W+1)'(64'sh8000_0000)) return 32'sh8000_0000;
        return x[31:0];
    endfunction

    t_state r_state, n_state;

    logic [30:0]              r_gamma, r_tstep;
    logic [IDX_W-1:0]         r_next_idx, r_idx, r_rd_addr;
    logic signed [31:0]       r_left_hold, r_f, r_right, r_y;
    logic                     r_start;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [MQ_W-1:0]   r_den, r_rhs, r_num;

    logic                     in_fire, out_fire, cfg_we;
    logic [IDX_W-1:0]         load_idx, load_next, fw_i;
    logic                     fw_start;
    logic signed [OPND_W-1:0] mul_a, mul_b;
    logic signed [MQ_W-1:0]   c_val, div_num;
    logic                     div_start, div_done;
    logic signed [31:0]       div_quot;
    logic [IDX_W-1:0]         idx_p1;

    logic                     g_we, a_we, b_we;
    logic [IDX_W-1:0]         g_waddr, a_waddr, b_waddr;
    logic [31:0]              g_wdata, a_wdata, b_wdata;
    logic [31:0]              g_rd, a_rd, b_rd;
    logic signed [31:0]       alpha_v, beta_v;

    // config port
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_GAMMA) ? {1'b0, r_gamma} : {1'b0, r_tstep};

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    assign load_idx  = (r_next_idx > N_IDX) ? '0 : r_next_idx;
    assign load_next = (load_idx >= N_IDX) ? '0 : load_idx + IDX_ONE;
    assign fw_start  = (r_next_idx == '0) || (r_next_idx >= N_IDX);
    assign fw_i      = fw_start ? IDX_ONE : r_next_idx;
    assign idx_p1    = r_idx + IDX_ONE;

    assign c_val   = MQ_W'(Q_ONE) + MQ_W'({r_gamma, 1'b0});
    assign alpha_v = r_start ? 32'sd0 : $signed(a_rd);
    assign beta_v  = r_start ? r_left_hold : $signed(b_rd);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:   if (in_fire && i_op == OP_FORCE) n_state = ST_FW_RD;
            ST_FW_RD:  n_state = ST_FW_M1;
            ST_FW_M1:  n_state = ST_FW_M2;
            ST_FW_M2:  n_state = ST_FW_M3;
            ST_FW_M3:  n_state = ST_FW_M4;
            ST_FW_M4:  n_state = ST_DIV_A;
            ST_DIV_A:  if (div_done) n_state = ST_DIV_B;
            ST_DIV_B: begin
                if (div_done) n_state = (idx_p1 < N_IDX) ? ST_IDLE : ST_BS_OUT;
            end
            ST_BS_OUT: begin
                if (out_fire) begin
                    if (r_idx == '0) n_state = ST_IDLE;
                    else if (r_idx == IDX_ONE) n_state = ST_BS_OUT;
                    else n_state = ST_BS_RD;
                end
            end
            ST_BS_RD:  n_state = ST_BS_MUL;
            ST_BS_MUL: n_state = ST_BS_ADD;
            ST_BS_ADD: n_state = ST_BS_OUT;
            default:   n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath control
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_out_valid = (r_state == ST_BS_OUT);
        mul_a = '0;
        mul_b = '0;
        div_start = 1'b0;
        div_num   = r_num;
        g_we = 1'b0; g_waddr = load_idx; g_wdata = i_sample_value;
        a_we = 1'b0; a_waddr = IDX_ONE;  a_wdata = '0;
        b_we = 1'b0; b_waddr = IDX_ONE;  b_wdata = i_left_edge;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_op == OP_LOAD) g_we = 1'b1;
                // a new step seeds alpha[1] = 0, beta[1] = left edge
                if (in_fire && i_op == OP_FORCE && fw_start) begin
                    a_we = 1'b1;
                    b_we = 1'b1;
                end
            end
            ST_FW_M1: begin
                mul_a = OPND_W'(alpha_v);
                mul_b = $signed({2'b00, r_gamma});
            end
            ST_FW_M2: begin
                mul_a = $signed({2'b00, r_tstep});
                mul_b = OPND_W'(r_f);
            end
            ST_FW_M3: begin
                mul_a = $signed({2'b00, r_gamma});
                mul_b = OPND_W'(beta_v);
            end
            ST_FW_M4: begin
                div_start = 1'b1;
                div_num   = MQ_W'({r_gamma});
            end
            ST_DIV_A: begin
                if (div_done) begin
                    a_we = 1'b1; a_waddr = idx_p1; a_wdata = div_quot;
                    div_start = 1'b1;
                end
            end
            ST_DIV_B: begin
                if (div_done) begin
                    b_we = 1'b1; b_waddr = idx_p1; b_wdata = div_quot;
                end
            end
            ST_BS_OUT: begin
                if (out_fire) begin
                    g_we = 1'b1; g_waddr = r_idx; g_wdata = r_y;
                end
            end
            ST_BS_MUL: begin
                mul_a = OPND_W'($signed(a_rd));
                mul_b = OPND_W'(r_y);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_gamma     <= 31'd1048576;
            r_tstep     <= 31'd4096;
            r_next_idx  <= '0;
            r_left_hold <= '0;
        end else begin
            r_state <= n_state;
            if (cfg_we) begin
                if (paddr[2] == REG_GAMMA) r_gamma <= pwdata[30:0];
                else r_tstep <= pwdata[30:0];
            end
            if (in_fire && i_op == OP_LOAD) r_next_idx <= load_next;
            if (in_fire && i_op == OP_FORCE && fw_start) r_left_hold <= i_left_edge;
            if (r_state == ST_DIV_B && div_done && idx_p1 < N_IDX) r_next_idx <= idx_p1;
            if (r_state == ST_BS_OUT && out_fire && r_idx == '0) r_next_idx <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            ST_IDLE: begin
                if (in_fire && i_op == OP_FORCE) begin
                    r_idx     <= fw_i;
                    r_rd_addr <= fw_i;
                    r_start   <= fw_start;
                    r_f       <= i_sample_value;
                    r_right   <= i_right_edge;
                end
            end
            ST_FW_M2: r_den <= c_val - mq(r_prod);
            ST_FW_M3: r_rhs <= -MQ_W'($signed(g_rd)) - mq(r_prod);
            ST_FW_M4: r_num <= mq(r_prod) - r_rhs;
            ST_DIV_B: begin
                if (div_done && !(idx_p1 < N_IDX)) begin
                    r_idx <= N_IDX;
                    r_y   <= r_right;
                end
            end
            ST_BS_OUT: begin
                if (out_fire) begin
                    if (r_idx == IDX_ONE) begin
                        r_idx <= '0;
                        r_y   <= r_left_hold;
                    end else if (r_idx != '0) begin
                        r_idx     <= r_idx - IDX_ONE;
                        r_rd_addr <= r_idx;
                    end
                end
            end
            ST_BS_ADD: r_y <= sat32((MQ_W+1)'(mq(r_prod)) + (MQ_W+1)'($signed(b_rd)));
            default: ;
        endcase
    end

    assign o_point_index = 6'(r_idx);
    assign o_point_value = r_y;
    assign o_last_point  = (r_idx == '0);

    ihs_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    ihs_ram #(.WIDTH(32), .DEPTH(NPTS)) u_grid (
        .i_clk(i_clk), .i_we(g_we), .i_waddr(g_waddr), .i_wdata(g_wdata),
        .i_raddr(r_rd_addr), .o_rdata(g_rd)
    );

    ihs_ram #(.WIDTH(32), .DEPTH(NPTS)) u_alpha (
        .i_clk(i_clk), .i_we(a_we), .i_waddr(a_waddr), .i_wdata(a_wdata),
        .i_raddr(r_rd_addr), .o_rdata(a_rd)
    );

    ihs_ram #(.WIDTH(32), .DEPTH(NPTS)) u_beta (
        .i_clk(i_clk), .i_we(b_we), .i_waddr(b_waddr), .i_wdata(b_wdata),
        .i_raddr(r_rd_addr), .o_rdata(b_rd)
    );

    `ASSERT_NEVER(a_no_overlap, i_clk, i_rst_n, o_out_valid && o_in_ready)
    `ASSERT_AT(a_last_is_zero, i_clk, i_rst_n, o_out_valid && o_last_point |-> o_point_index == 6'd0)
    `ASSERT_AT(a_back_to_idle, i_clk, i_rst_n, out_fire && o_last_point |=> o_in_ready)
    `ASSERT_NEVER(a_div_busy, i_clk, i_rst_n, div_done && o_in_ready)

endmodule

// ----- hdl/ihs_ram.sv -----
// ----------------------------------------------------------------------------
// ihs_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ihs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 33
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/ihs_div.sv -----
// ----------------------------------------------------------------------------
// ihs_div
// Serial Q16.16 divider: trunc(num * 2^16 / den), saturated to 32 bits.
// ----------------------------------------------------------------------------
module ihs_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [ihs_pkg::MQ_W-1:0] i_num,
    input  logic signed [ihs_pkg::MQ_W-1:0] i_den,
    output logic                      o_done,
    output logic signed [31:0]        o_quot
);
    import ihs_pkg::*;

    localparam int DVD_W = MQ_W + FRAC_W;
    localparam int QB    = 33;

    t_div_state r_state, n_state;
    logic [DVD_W-1:0] r_dvd;
    logic [MQ_W-1:0]  r_dvs;
    logic [MQ_W-1:0]  r_rem;
    logic [QB-1:0]    r_low;
    logic [QB-1:0]    r_q;
    logic [5:0]       r_cnt;
    logic             r_neg, r_num_neg, r_zero, r_ovf;

    logic             load;
    logic [MQ_W-1:0]  num_mag, den_mag;
    logic [MQ_W:0]    trial, trial_sub;
    logic             ge;
    logic [QB-1:0]    q_neg;

    assign load    = i_start && (r_state == DV_IDLE || r_state == DV_DONE);
    assign num_mag = i_num[MQ_W-1] ? MQ_W'(-i_num) : MQ_W'(i_num);
    assign den_mag = i_den[MQ_W-1] ? MQ_W'(-i_den) : MQ_W'(i_den);
    assign trial     = {r_rem, r_low[QB-1]};
    assign trial_sub = trial - {1'b0, r_dvs};
    assign ge        = trial >= {1'b0, r_dvs};

    always_comb begin
        n_state = r_state;
        case (r_state)
            DV_IDLE:  if (load) n_state = DV_CHECK;
            DV_CHECK: n_state = DV_ITER;
            DV_ITER:  if (r_cnt == 6'(QB - 1)) n_state = DV_DONE;
            DV_DONE:  n_state = load ? DV_CHECK : DV_IDLE;
            default:  n_state = DV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_dvd     <= {num_mag, FRAC_W'(0)};
            r_dvs     <= den_mag;
            r_neg     <= i_num[MQ_W-1] ^ i_den[MQ_W-1];
            r_num_neg <= i_num[MQ_W-1];
            r_zero    <= (i_den == '0);
        end
        if (r_state == DV_CHECK) begin
            // quotient must fit in QB bits, else it saturates
            r_ovf <= MQ_W'(r_dvd[DVD_W-1:QB]) >= r_dvs;
            r_rem <= MQ_W'(r_dvd[DVD_W-1:QB]);
            r_low <= r_dvd[QB-1:0];
            r_q   <= '0;
            r_cnt <= '0;
        end
        if (r_state == DV_ITER) begin
            r_rem <= ge ? trial_sub[MQ_W-1:0] : trial[MQ_W-1:0];
            r_low <= {r_low[QB-2:0], 1'b0};
            r_q   <= {r_q[QB-2:0], ge};
            r_cnt <= r_cnt + 6'd1;
        end
    end

    assign q_neg = -r_q;

    always_comb begin
        if (r_zero) begin
            o_quot = r_num_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (r_ovf) begin
            o_quot = r_neg ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end else if (r_neg) begin
            o_quot = (r_q > QB'(33'h0_8000_0000)) ? 32'sh8000_0000 : q_neg[31:0];
        end else begin
            o_quot = (r_q > QB'(33'h0_7fff_ffff)) ? 32'sh7fff_ffff : r_q[31:0];
        end
    end

    assign o_done = (r_state == DV_DONE);

endmodule

// ----- bench/ihs_checker.sv -----
// ----------------------------------------------------------------------------
// ihs_checker
// Predicts and checks the result stream of the implicit heat step unit.
// ----------------------------------------------------------------------------
// Watches the config port and the input channel, runs its own Thomas sweep on
// every accepted forcing transaction and compares each accepted result in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ihs_checker #(
    parameter int GRID_N = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  logic               i_op,
    input  logic signed [31:0] i_sample_value,
    input  logic signed [31:0] i_left_edge,
    input  logic signed [31:0] i_right_edge,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [5:0]         i_point_index,
    input  logic signed [31:0] i_point_value,
    input  logic               i_last_point,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    import ihs_pkg::*;

    typedef struct {
        logic [5:0]         idx;
        logic signed [31:0] val;
        logic               last;
    } t_grid_point;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    t_grid_point        new_points_q[$];
    logic signed [31:0] heat_grid   [0:GRID_N];
    logic signed [31:0] sweep_alpha [0:GRID_N];
    logic signed [31:0] sweep_beta  [0:GRID_N];
    int                 point_cursor;
    logic signed [31:0] edge_left;
    longint             coef_gamma;
    longint             coef_tau;

    // Q16.16 product, floor rounding
    function automatic longint fx_mul(longint a, longint b);
        return (a * b) >>> 16;
    endfunction

    function automatic logic signed [31:0] clamp32(longint x);
        if (x > S32_MAX) return 32'sh7FFFFFFF;
        if (x < S32_MIN) return 32'sh80000000;
        return x[31:0];
    endfunction

    // num * 2^16 / den, truncated toward zero, saturated
    function automatic logic signed [31:0] fx_div(longint num, longint den);
        logic signed [127:0] n, d, q, r, res;
        if (den == 0) return (num >= 0) ? 32'sh7FFFFFFF : 32'sh80000000;
        n = num;
        d = den;
        q = n / d;
        r = n % d;
        if (q > 65536) return 32'sh7FFFFFFF;
        if (q < -65536) return 32'sh80000000;
        res = q * 65536 + (r * 65536) / d;
        if (res > S32_MAX) return 32'sh7FFFFFFF;
        if (res < S32_MIN) return 32'sh80000000;
        return res[31:0];
    endfunction

    task automatic predict_item(logic p_op, logic signed [31:0] s,
                                logic signed [31:0] le, logic signed [31:0] re);
        int                 i;
        longint             den, rhs, num;
        logic signed [31:0] y;
        t_grid_point        pt;
        if (p_op == OP_LOAD) begin
            i = (point_cursor > GRID_N) ? 0 : point_cursor;
            heat_grid[i] = s;
            point_cursor = (i >= GRID_N) ? 0 : i + 1;
            return;
        end
        i = point_cursor;
        if (i == 0 || i >= GRID_N) begin
            // new step: capture the left boundary
            i = 1;
            edge_left = le;
            sweep_alpha[1] = '0;
            sweep_beta[1] = le;
        end
        den = 65536 + 2 * coef_gamma - fx_mul(longint'(sweep_alpha[i]), coef_gamma);
        rhs = -longint'(heat_grid[i]) - fx_mul(coef_tau, longint'(s));
        num = fx_mul(coef_gamma, longint'(sweep_beta[i])) - rhs;
        sweep_alpha[i + 1] = fx_div(coef_gamma, den);
        sweep_beta[i + 1] = fx_div(num, den);
        if (i + 1 < GRID_N) begin
            point_cursor = i + 1;
            return;
        end
        y = re;
        for (int k = GRID_N; k >= 0; k--) begin
            if (k == 0)
                y = edge_left;
            else if (k < GRID_N)
                y = clamp32(fx_mul(longint'(sweep_alpha[k + 1]), longint'(y))
                            + longint'(sweep_beta[k + 1]));
            heat_grid[k] = y;
            pt.idx = k[5:0];
            pt.val = y;
            pt.last = (k == 0);
            new_points_q.push_back(pt);
        end
        point_cursor = 0;
    endtask

    task automatic report_mismatch(string what);
        $display("%0t ns: mismatch: %s", $realtime, what);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_grid_point exp_pt;
        if (!i_rst_n) begin
            new_points_q.delete();
            point_cursor = 0;
            edge_left = '0;
            coef_gamma = 1048576;
            coef_tau = 4096;
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_GAMMA)
                    coef_gamma = longint'(i_pwdata[30:0]);
                else
                    coef_tau = longint'(i_pwdata[30:0]);
            end
            if (i_in_valid && i_in_ready)
                predict_item(i_op, i_sample_value, i_left_edge, i_right_edge);
            if (i_out_valid && i_out_ready) begin
                if (new_points_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected point index %0d", i_point_index));
                end else begin
                    exp_pt = new_points_q.pop_front();
                    if (i_point_index !== exp_pt.idx)
                        report_mismatch($sformatf("index %0d, want %0d",
                                                  i_point_index, exp_pt.idx));
                    if (i_point_value !== exp_pt.val)
                        report_mismatch($sformatf("index %0d value %0d, want %0d",
                                                  exp_pt.idx, i_point_value, exp_pt.val));
                    if (i_last_point !== exp_pt.last)
                        report_mismatch($sformatf("index %0d last flag %b, want %b",
                                                  exp_pt.idx, i_last_point, exp_pt.last));
                end
            end
        end
        o_pending = new_points_q.size();
    end

endmodule

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the implicit heat step tridiagonal unit.
// ----------------------------------------------------------------------------
// Loads a grid, runs directed steps at the value extremes, then random steps
// with noise under several coefficient settings and back-pressure patterns.
// Checking is done by ihs_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
    import ihs_pkg::*;

    localparam int GRID_N = 32;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_ready;
    logic               i_op;
    logic signed [31:0] i_sample_value;
    logic signed [31:0] i_left_edge;
    logic signed [31:0] i_right_edge;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [5:0]         o_point_index;
    logic signed [31:0] o_point_value;
    logic               o_last_point;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [2:0]         paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int   fail_count;
    int   pending;
    int   items_sent;
    int   send_idle_pct;
    int   recv_idle_pct;
    logic holdoff_req;
    logic holdoff_done;

    implicit_heat_step_tridiagonal_unit #(.GRID_INTERVALS(GRID_N)) DUT (.*);

    ihs_checker #(.GRID_N(GRID_N)) checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_ready(o_in_ready), .i_op(i_op),
        .i_sample_value(i_sample_value), .i_left_edge(i_left_edge),
        .i_right_edge(i_right_edge),
        .i_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_point_index(o_point_index), .i_point_value(o_point_value),
        .i_last_point(o_last_point),
        .i_psel(psel), .i_penable(penable), .i_pwrite(pwrite),
        .i_paddr(paddr), .i_pwdata(pwdata), .i_pready(pready),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    // result side back-pressure; a hold-off request stalls it once for a long stretch
    initial begin
        i_out_ready = 1'b0;
        holdoff_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (holdoff_req && !holdoff_done) begin
                i_out_ready = 1'b0;
                repeat (2500) @(negedge i_clk);
                holdoff_done = 1'b1;
            end else begin
                i_out_ready = ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    function automatic logic signed [31:0] rand_q16();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFFFFFF;
            1:       return 32'sh80000000;
            2:       return '0;
            3:       return $signed($urandom_range(0, 131071)) - 65536;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_item(logic p_op, logic signed [31:0] s,
                             logic signed [31:0] le, logic signed [31:0] re);
        @(negedge i_clk);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_op = p_op;
        i_sample_value = s;
        i_left_edge = le;
        i_right_edge = re;
        forever begin
            @(posedge i_clk);
            if (o_in_ready) break;
        end
        items_sent++;
        // phase of idling follows progress through the run
        if (items_sent < 125) begin
            send_idle_pct = 14;
            recv_idle_pct = 72;
        end else if (items_sent < 250) begin
            send_idle_pct = 72;
            recv_idle_pct = 14;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
    endtask

    task automatic full_step();
        for (int p = 1; p < GRID_N; p++)
            send_item(OP_FORCE, rand_q16(), rand_q16(), rand_q16());
    endtask

    task automatic full_reload();
        for (int p = 0; p <= GRID_N; p++)
            send_item(OP_LOAD, rand_q16(), rand_q16(), rand_q16());
    endtask

    // drain results, then allow for a forcing transaction still in the divider
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic reg_idx, logic [31:0] value);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    initial begin
        logic [31:0] gamma_set[4];
        logic [31:0] tau_set[4];
        int          target;
        int          pick;
        gamma_set = '{32'h7FFFFFFF, 32'h0, 32'h0004_0000, 32'h0};
        tau_set   = '{32'h0, 32'h7FFFFFFF, 32'h0000_1000, 32'h0};
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_op = OP_LOAD;
        i_sample_value = '0;
        i_left_edge = '0;
        i_right_edge = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        holdoff_req = 1'b0;
        items_sent = 0;
        send_idle_pct = 14;
        recv_idle_pct = 72;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        cfg_write(REG_GAMMA, 32'h0001_0000);
        cfg_write(REG_TSTEP, 32'h0000_1000);

        // directed: grid at extremes, then a step with extreme boundaries
        for (int p = 0; p <= GRID_N; p++)
            send_item(OP_LOAD, (p % 4 == 0) ? 32'sh7FFFFFFF : (p % 4 == 1) ? 32'sh80000000 :
                      (p % 4 == 2) ? 32'sh0 : -32'sd1, '0, '0);
        for (int p = 1; p < GRID_N; p++)
            send_item(OP_FORCE, (p % 2) ? 32'sh7FFFFFFF : 32'sh80000000,
                      32'sh7FFFFFFF, 32'sh80000000);
        full_step();

        for (int phase = 0; phase < 4; phase++) begin
            settle();
            gamma_set[3] = $urandom_range(0, 32'h7FFFFFFF) >> $urandom_range(0, 14);
            tau_set[3] = $urandom_range(0, 32'h7FFFFFFF) >> $urandom_range(0, 14);
            cfg_write(REG_GAMMA, gamma_set[phase]);
            cfg_write(REG_TSTEP, tau_set[phase]);
            if (phase == 3) holdoff_req = 1'b1;
            target = items_sent + 45;
            while (items_sent < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 72) begin
                    full_step();
                end else if (pick < 84) begin
                    full_reload();
                end else begin
                    // noise: stray loads and forcings that shift the sweep point
                    repeat ($urandom_range(1, 4))
                        send_item(1'($urandom_range(0, 1)), rand_q16(), rand_q16(),
                                  rand_q16());
                end
            end
        end
        full_step();

        settle();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/ihs_pkg.sv
hdl/ihs_ram.sv
hdl/ihs_div.sv
hdl/implicit_heat_step_tridiagonal_unit.sv
bench/ihs_checker.sv
bench/testbench.sv
